// File: sv/rhsv_pkg.sv
`default_nettype none

package rhsv_pkg;

  // Channel and quotient widths.
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned Q_W = 8;

  // Saturation divide: numerator 255*d, divisor max.
  localparam int unsigned SAT_N_W = 16;
  // Hue divide: numerator 255*num (num < 6d), divisor 6d.
  localparam int unsigned HUE_D_W = 11;
  localparam int unsigned HUE_N_W = 19;
  // Signed channel difference.
  localparam int unsigned DIFF_W = CHAN_W + 1;

  localparam logic [CHAN_W-1:0] FULL_SCALE = 8'hFF;

  // Which channel holds the maximum.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // Result of the sorting stage.
  typedef struct packed {
    logic [CHAN_W-1:0]        hi;
    logic [CHAN_W-1:0]        d;
    logic signed [DIFF_W-1:0] diff;
    sector_e                  sec;
  } sort_t;

  // State carried through the divider steps; both divides run side by side.
  typedef struct packed {
    logic [SAT_N_W-1:0] sat_rem;
    logic [SAT_N_W-1:0] sat_den;
    logic [Q_W-1:0]     sat_q;
    logic [HUE_N_W-1:0] hue_rem;
    logic [HUE_N_W-1:0] hue_den;
    logic [Q_W-1:0]     hue_q;
    logic [CHAN_W-1:0]  hi;
    logic               black;
    logic               grey;
  } div_t;

endpackage

`default_nettype wire

// File: sv/rhsv_pix_if.sv
`default_nettype none

interface rhsv_pix_if;
  import rhsv_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

`default_nettype wire

// File: sv/rhsv_hsv_if.sv
`default_nettype none

interface rhsv_hsv_if;
  import rhsv_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] hue_out;
  logic [CHAN_W-1:0] sat_out;
  logic [CHAN_W-1:0] val_out;

  modport source (output valid, output hue_out, output sat_out, output val_out, input ready);
  modport sink (input valid, input hue_out, input sat_out, input val_out, output ready);
endinterface

`default_nettype wire

// File: sv/rhsv_sort.sv
`default_nettype none

module rhsv_sort import rhsv_pkg::*; (
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  output sort_t             sort_o
);

  logic [CHAN_W-1:0] lo;

  // Find the largest channel (red wins ties, then green) and the smallest.
  always_comb begin
    sort_o = '0;
    lo = red_i;
    if (green_i < lo) lo = green_i;
    if (blue_i < lo) lo = blue_i;

    if (red_i >= green_i && red_i >= blue_i) begin
      sort_o.sec  = SEC_RED;
      sort_o.hi   = red_i;
      sort_o.diff = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i >= blue_i) begin
      sort_o.sec  = SEC_GREEN;
      sort_o.hi   = green_i;
      sort_o.diff = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sort_o.sec  = SEC_BLUE;
      sort_o.hi   = blue_i;
      sort_o.diff = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
    sort_o.d = sort_o.hi - lo;
  end

endmodule

`default_nettype wire

// File: sv/rhsv_numer.sv
`default_nettype none

module rhsv_numer import rhsv_pkg::*; (
  input  sort_t sort_i,
  output div_t  div_o
);

  logic [HUE_D_W-1:0]        six;
  logic [HUE_D_W-1:0]        off;
  logic signed [HUE_D_W:0]   sum;
  logic signed [HUE_D_W:0]   wrap;
  logic [HUE_D_W-1:0]        num;

  // Sector offset plus channel difference, folded into 0 .. 6d-1.
  always_comb begin
    six = (HUE_D_W'(sort_i.d) << 2) + (HUE_D_W'(sort_i.d) << 1);
    case (sort_i.sec)
      SEC_RED:   off = '0;
      SEC_GREEN: off = HUE_D_W'(sort_i.d) << 1;
      SEC_BLUE:  off = HUE_D_W'(sort_i.d) << 2;
      default:   off = '0;
    endcase
    sum  = $signed({1'b0, off}) + $signed({{(HUE_D_W + 1 - DIFF_W){sort_i.diff[DIFF_W-1]}},
                                            sort_i.diff});
    wrap = sum + $signed({1'b0, six});
    num  = sum[HUE_D_W] ? wrap[HUE_D_W-1:0] : sum[HUE_D_W-1:0];
  end

  // Load both dividers: numerators times 255, divisors aligned to the top quotient bit.
  always_comb begin
    div_o.sat_rem = {sort_i.d, 8'h00} - SAT_N_W'(sort_i.d);
    div_o.sat_den = SAT_N_W'({sort_i.hi, {(Q_W-1){1'b0}}});
    div_o.sat_q   = '0;
    div_o.hue_rem = HUE_N_W'({num, 8'h00}) - HUE_N_W'(num);
    div_o.hue_den = HUE_N_W'({six, {(Q_W-1){1'b0}}});
    div_o.hue_q   = '0;
    div_o.hi      = sort_i.hi;
    div_o.black   = (sort_i.hi == '0);
    div_o.grey    = (sort_i.d == '0);
  end

endmodule

`default_nettype wire

// File: sv/rhsv_div_step.sv
`default_nettype none

module rhsv_div_step import rhsv_pkg::*; (
  input  div_t div_i,
  output div_t div_o
);

  // One restoring step for each divide: try the aligned divisor, keep the
  // difference if it fits, shift the quotient bit in and move the divisor down.
  always_comb begin
    div_o = div_i;
    if (div_i.sat_rem >= div_i.sat_den) begin
      div_o.sat_rem = div_i.sat_rem - div_i.sat_den;
      div_o.sat_q   = {div_i.sat_q[Q_W-2:0], 1'b1};
    end else begin
      div_o.sat_q   = {div_i.sat_q[Q_W-2:0], 1'b0};
    end
    div_o.sat_den = div_i.sat_den >> 1;

    if (div_i.hue_rem >= div_i.hue_den) begin
      div_o.hue_rem = div_i.hue_rem - div_i.hue_den;
      div_o.hue_q   = {div_i.hue_q[Q_W-2:0], 1'b1};
    end else begin
      div_o.hue_q   = {div_i.hue_q[Q_W-2:0], 1'b0};
    end
    div_o.hue_den = div_i.hue_den >> 1;
  end

endmodule

`default_nettype wire

// File: sv/rgb_to_hsv_pixel_top.sv
// Each accepted pixel beat is carried through the stages below to its HSV beat on the output.
// Throughput: one pixel per cycle; stages: sort, numerators, eight divider
// steps (one quotient bit each for hue and saturation), output register.
// A stalled output holds the pipeline; empty stages still fill behind it.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data is not reset.
`default_nettype none

module rgb_to_hsv_pixel_top import rhsv_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rhsv_pix_if.sink  pix_i,
  rhsv_hsv_if.source hsv_o
);

  localparam int unsigned N_STG = Q_W + 3;
  localparam int unsigned OUT_STG = N_STG - 1;

  logic [N_STG-1:0] vld_q;
  logic [N_STG-1:0] adv;

  sort_t sort_d, sort_q;
  div_t  init_d, init_q;
  div_t  step_d [Q_W];
  div_t  step_q [Q_W];

  logic [CHAN_W-1:0] hue_d, hue_q;
  logic [CHAN_W-1:0] sat_d, sat_q;
  logic [CHAN_W-1:0] val_q;

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    adv[OUT_STG] = !vld_q[OUT_STG] || hsv_o.ready;
    for (int i = OUT_STG - 1; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign pix_i.ready = adv[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= pix_i.valid;
      for (int i = 1; i < N_STG; i++) begin
        if (adv[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Sort stage.
  rhsv_sort u_sort (
    .red_i   (pix_i.red_in),
    .green_i (pix_i.green_in),
    .blue_i  (pix_i.blue_in),
    .sort_o  (sort_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv[0]) sort_q <= sort_d;
  end

  // Numerator stage.
  rhsv_numer u_numer (
    .sort_i (sort_q),
    .div_o  (init_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv[1]) init_q <= init_d;
  end

  // Divider steps, one register each.
  for (genvar k = 0; k < Q_W; k++) begin : g_div
    if (k == 0) begin : g_first
      rhsv_div_step u_step (
        .div_i (init_q),
        .div_o (step_d[k])
      );
    end else begin : g_next
      rhsv_div_step u_step (
        .div_i (step_q[k-1]),
        .div_o (step_d[k])
      );
    end

    always_ff @(posedge clk_i) begin
      if (adv[k+2]) step_q[k] <= step_d[k];
    end
  end

  // Black pixels override both quotients; grey pixels override the hue quotient.
  always_comb begin
    hue_d = (step_q[Q_W-1].black || step_q[Q_W-1].grey) ? '0 : step_q[Q_W-1].hue_q;
    sat_d = step_q[Q_W-1].black ? FULL_SCALE : step_q[Q_W-1].sat_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[OUT_STG]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= step_q[Q_W-1].hi;
    end
  end

  assign hsv_o.valid   = vld_q[OUT_STG];
  assign hsv_o.hue_out = hue_q;
  assign hsv_o.sat_out = sat_q;
  assign hsv_o.val_out = val_q;

endmodule

`default_nettype wire
